[sv/hbc_pkg.sv]
// Shared types, constants and codes for the histogram binning counter.
package hbc_pkg;

  // Capacity and counter width
  localparam int unsigned MAX_BINS = 64;
  localparam int unsigned COUNT_W  = 20;
  localparam int unsigned BIN_W    = $clog2(MAX_BINS);

  // Field widths fixed by the interface
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OUT_BIN_W = 6;
  localparam int unsigned BCNT_W    = 7;
  localparam int unsigned CFG_AW    = 2;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_VALUE = 2'd0,
    REG_BIN_SCALE = 2'd1,
    REG_BIN_COUNT = 2'd2
  } reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_RD,
    ST_WB
  } state_e;

  // Input word
  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] sample;
    logic [OUT_BIN_W-1:0]     read_index;
  } in_t;

  // Output word
  typedef struct packed {
    logic [OUT_BIN_W-1:0] bin;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   peak_count;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic idx;
    logic rd;
    logic wb;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

[sv/histogram_binning_counter.sv]
// Top level of the fixed-range histogram engine.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o | in_word_i (func, sample, idx)
//  out     | output    | out_valid_o/out_stall_i | out_word_o (bin, count, peak)
//  cfg     | input     | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
// Each word goes through these steps: accept with subtract, 32x32 multiply,
// clamp/index, bin memory read, write-back; the controller runs them one word
// at a time and takes no new word before write-back. Next word is taken the
// cycle after write-back, while the result may still wait in the output
// register. Write-back holds only while the previous result is still stalled.
// Reset is asynchronous; bins read as zero after reset through per-bin
// valid bits, so there is no clearing pass.
module histogram_binning_counter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hbc_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [hbc_pkg::DATA_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hbc_pkg::in_t               in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hbc_pkg::out_t              out_word_o
);
  import hbc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  hbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  hbc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[sv/hbc_ctrl.sv]
// Sequencing state machine for the histogram binning counter.
module hbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hbc_pkg::stat_t stat_i,
  output hbc_pkg::cmd_t  cmd_o
);
  import hbc_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_IDX;
      ST_IDX:  state_d = ST_RD;
      ST_RD:   state_d = ST_WB;
      ST_WB: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_IDX:  cmd_o.idx = 1'b1;
      ST_RD:   cmd_o.rd  = 1'b1;
      ST_WB:   cmd_o.wb  = !stat_i.out_busy;
      default: cmd_o     = '0;
    endcase
  end

  // Checks
  a_load_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL)
    else $error("accepted word did not start the multiply step");
  a_wb_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |=> state_q == ST_IDLE)
    else $error("write-back did not return to idle");
  a_rd_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> state_q == ST_WB)
    else $error("memory read not followed by write-back");

endmodule

[sv/hbc_datapath.sv]
// Index arithmetic, bin memory, peak tracking and output register.
module hbc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbc_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [hbc_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  hbc_pkg::in_t                  in_word_i,
  input  hbc_pkg::cmd_t                 cmd_i,
  output hbc_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hbc_pkg::out_t                 out_word_o
);
  import hbc_pkg::*;

  // Configuration registers
  logic signed [DATA_W-1:0] min_value_q;
  logic [DATA_W-1:0]        bin_scale_q;
  logic [BCNT_W-1:0]        bin_count_q;

  // Item pipeline registers
  logic [1:0]             func_q;
  logic [OUT_BIN_W-1:0]   read_idx_q;
  logic signed [DATA_W:0] diff_q;
  logic [2*DATA_W-1:0]    prod_q;
  logic                   pos_q;
  logic [BIN_W-1:0]       bin_q;
  logic                   rd_ok_q;

  // Bin memory, valid bits and read data
  logic [COUNT_W-1:0] bin_mem_q [MAX_BINS];
  logic [MAX_BINS-1:0] vld_q;
  logic [COUNT_W-1:0] mem_rd_q;
  logic               vld_rd_q;

  // Peak and output
  logic [COUNT_W-1:0] peak_q;
  logic               out_valid_q;
  out_t               out_q;

  // Combinational helpers
  logic [DATA_W-1:0]  bc32;
  logic [DATA_W-1:0]  top32;
  logic [DATA_W-1:0]  hi32;
  logic [BIN_W-1:0]   add_bin;
  logic [BIN_W-1:0]   idx_bin;
  logic [DATA_W-1:0]  bin32;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] inc_cnt;
  logic               is_add;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q <= '0;
      bin_scale_q <= 32'd65536;
      bin_count_q <= BCNT_W'(MAX_BINS);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MIN_VALUE: min_value_q <= cfg_wdata_i;
        REG_BIN_SCALE: bin_scale_q <= cfg_wdata_i;
        REG_BIN_COUNT: bin_count_q <= cfg_wdata_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Top bin in use, clamped to 1..MAX_BINS bins
  assign bc32 = DATA_W'(bin_count_q);
  always_comb begin
    if (bc32 == '0) begin
      top32 = '0;
    end else if (bc32 > DATA_W'(MAX_BINS)) begin
      top32 = DATA_W'(MAX_BINS - 1);
    end else begin
      top32 = bc32 - 1'b1;
    end
  end

  // Integer part of the product, clamped
  assign hi32    = prod_q[2*DATA_W-1:DATA_W];
  assign add_bin = !pos_q ? '0 :
                   (hi32 > top32) ? top32[BIN_W-1:0] : hi32[BIN_W-1:0];

  always_comb begin
    case (func_q)
      FUNC_ADD:  idx_bin = add_bin;
      FUNC_READ: idx_bin = read_idx_q[BIN_W-1:0];
      default:   idx_bin = '0;
    endcase
  end

  // Accept, multiply and index stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= in_word_i.func;
      read_idx_q <= in_word_i.read_index;
      diff_q     <= (DATA_W+1)'(in_word_i.sample) - (DATA_W+1)'(min_value_q);
    end
    if (cmd_i.mul) begin
      prod_q <= (2*DATA_W)'(diff_q[DATA_W-1:0]) * (2*DATA_W)'(bin_scale_q);
      pos_q  <= !diff_q[DATA_W] && (diff_q != '0);
    end
    if (cmd_i.idx) begin
      bin_q   <= idx_bin;
      rd_ok_q <= DATA_W'(read_idx_q) < DATA_W'(MAX_BINS);
    end
  end

  assign is_add  = (func_q == FUNC_ADD);
  assign cur_cnt = vld_rd_q ? mem_rd_q : '0;
  assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

  // Bin memory: registered read, write on write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      mem_rd_q <= bin_mem_q[bin_q];
    end
    if (cmd_i.wb && is_add) begin
      bin_mem_q[bin_q] <= inc_cnt;
    end
  end

  // Valid bits: clear drops all, add marks its bin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.rd) vld_rd_q <= vld_q[bin_q];
      if (cmd_i.wb && func_q == FUNC_CLEAR) begin
        vld_q <= '0;
      end else if (cmd_i.wb && is_add) begin
        vld_q[bin_q] <= 1'b1;
      end
    end
  end

  // Peak tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (cmd_i.wb) begin
      if (func_q == FUNC_CLEAR) begin
        peak_q <= '0;
      end else if (is_add && inc_cnt > peak_q) begin
        peak_q <= inc_cnt;
      end
    end
  end

  // Output word register
  assign bin32 = DATA_W'(bin_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      case (func_q)
        FUNC_ADD: begin
          out_q.bin        <= bin32[OUT_BIN_W-1:0];
          out_q.count      <= inc_cnt;
          out_q.peak_count <= (inc_cnt > peak_q) ? inc_cnt : peak_q;
        end
        FUNC_READ: begin
          out_q.bin        <= read_idx_q;
          out_q.count      <= rd_ok_q ? cur_cnt : '0;
          out_q.peak_count <= peak_q;
        end
        FUNC_CLEAR: begin
          out_q.bin        <= '0;
          out_q.count      <= '0;
          out_q.peak_count <= '0;
        end
        default: begin
          out_q.bin        <= '0;
          out_q.count      <= '0;
          out_q.peak_count <= peak_q;
        end
      endcase
    end
  end

  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;

  // Checks
  a_peak_covers_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.peak_count >= out_q.count)
    else $error("returned count exceeds peak");
  a_clear_drops_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wb && func_q == FUNC_CLEAR) |=> (vld_q == '0 && peak_q == '0))
    else $error("clear left a bin or the peak set");
  a_add_marks_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wb && is_add) |=> vld_q[$past(bin_q)])
    else $error("added bin not marked valid");

endmodule
